// ----- rtl/epnc_pkg.sv -----
// ----------------------------------------------------------------------------
// epnc_pkg
// Shared types and constants of the edge period note classifier: field
// widths, register indexes, reset values and the reciprocal numerator.
// ----------------------------------------------------------------------------
package epnc_pkg;

  localparam int unsigned NUM_NOTES = 8;
  localparam int unsigned NoteIdxW  = 3;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned FreqW     = 22;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 3;

  // numerator of 1e6 / period in q.8
  localparam int unsigned NumerW    = 28;
  localparam logic [NumerW-1:0] FreqNumerator = 28'd256000000;
  localparam logic [FreqW-1:0]  FreqMax       = {FreqW{1'b1}};

  typedef logic [TimeW-1:0]    time_t;
  typedef logic [FreqW-1:0]    freq_t;
  typedef logic [NoteIdxW-1:0] note_idx_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef enum logic {
    OpEdge = 1'b0,
    OpPoll = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegDebounce  = 3'd0,
    RegTimeout   = 3'd1,
    RegTolerance = 3'd2,
    RegNotesLow  = 3'd3,
    RegNotesHigh = 3'd4
  } cfg_reg_e;

  localparam logic [15:0]         DebounceRst  = 16'd100;
  localparam logic [TimeW-1:0]    TimeoutRst   = 32'd100000;
  localparam logic [15:0]         ToleranceRst = 16'd30;
  localparam logic [CfgDataW-1:0] NotesLowRst  = 64'd99362084137009410;
  localparam logic [CfgDataW-1:0] NotesHighRst = 64'd147213538857386376;

endpackage

// ----- rtl/edge_period_note_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// edge_period_note_classifier_unit
// Measures a signal period from time-stamped rising edges and, on a poll,
// reports the frequency in q.8 and the nearest entry of the note table.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | in        | in_valid_i / in_stall_o  | operation_i, time_us_i
//  out     | out       | out_valid_o / out_stall_i| match_status_o,
//          |           |                          | note_index_o, frequency_q8_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// An edge, or a poll that holds no period, is handled in its accept cycle.
// A poll that holds a period passes through the accept cycle, 28 steps of
// the shared restoring divider, a step to saturate the quotient, 8 steps of
// the shared distance compare, then the load of the output register, which
// waits while a still-full output register is stalled.
// Reset is asynchronous and active low; the config port is always ready.
// ----------------------------------------------------------------------------
module edge_period_note_classifier_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  epnc_pkg::time_t      time_us_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 match_status_o,
  output epnc_pkg::note_idx_t  note_index_o,
  output epnc_pkg::freq_t      frequency_q8_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  epnc_pkg::cfg_idx_t   cfg_index_i,
  input  epnc_pkg::cfg_data_t  cfg_data_i
);
  import epnc_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StCmp  = 4'b0100,
    StDone = 4'b1000
  } state_e;

  localparam logic [4:0]          DivLast  = 5'(NumerW - 1);
  localparam logic [NoteIdxW-1:0] NoteLast = NoteIdxW'(NUM_NOTES - 1);

  state_e state_q, state_d;

  logic [15:0]         debounce_q;
  time_t               timeout_q;
  logic [15:0]         tolerance_q;
  logic [CfgDataW-1:0] notes_lo_q, notes_hi_q;

  time_t last_edge_q, last_edge_d;
  time_t last_sig_q, last_sig_d;
  logic  waiting_q, waiting_d;
  logic  per_valid_q, per_valid_d;
  time_t period_q, period_d;

  logic [NumerW-1:0]   quo_q, quo_d;
  time_t               rem_q, rem_d;
  logic [4:0]          div_cnt_q, div_cnt_d;
  logic [NoteIdxW-1:0] note_cnt_q, note_cnt_d;
  freq_t               freq_q, freq_d;
  logic [23:0]         best_q, best_d;
  note_idx_t           best_idx_q, best_idx_d;

  logic      out_valid_q, out_valid_d;
  logic      match_q, match_d;
  note_idx_t out_idx_q, out_idx_d;
  freq_t     out_freq_q, out_freq_d;

  logic [15:0] notes [8];
  logic        in_beat;
  time_t       sig_eff;
  logic [TimeW:0] rem_shift;
  logic        rem_ge;
  logic [23:0] note_q8, note_dist;

  for (genvar g = 0; g < 4; g++) begin : g_notes
    assign notes[g]   = notes_lo_q[16*g +: 16];
    assign notes[g+4] = notes_hi_q[16*g +: 16];
  end

  assign in_stall_o  = (state_q != StIdle);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign sig_eff   = (time_us_i < last_sig_q) ? time_us_i : last_sig_q;
  assign rem_shift = {rem_q, quo_q[NumerW-1]};
  assign rem_ge    = rem_shift >= {1'b0, period_q};
  assign note_q8   = {notes[note_cnt_q], 8'h00};
  assign note_dist = (note_q8 > 24'(freq_q)) ? note_q8 - 24'(freq_q)
                                             : 24'(freq_q) - note_q8;

  always_comb begin
    state_d     = state_q;
    last_edge_d = last_edge_q;
    last_sig_d  = last_sig_q;
    waiting_d   = waiting_q;
    per_valid_d = per_valid_q;
    period_d    = period_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    note_cnt_d  = note_cnt_q;
    freq_d      = freq_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    match_d     = match_q;
    out_idx_d   = out_idx_q;
    out_freq_d  = out_freq_q;

    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          if (op_e'(operation_i) == OpEdge) begin
            if ((time_us_i - last_edge_q) > TimeW'(debounce_q)) begin
              last_sig_d  = time_us_i;
              last_edge_d = time_us_i;
              if (waiting_q) begin
                waiting_d = 1'b0;
              end else begin
                period_d    = time_us_i - last_edge_q;
                per_valid_d = 1'b1;
              end
            end
          end else begin
            last_sig_d = sig_eff;
            if ((time_us_i - sig_eff) > timeout_q) begin
              per_valid_d = 1'b0;
              waiting_d   = 1'b1;
            end else if (per_valid_q) begin
              quo_d     = FreqNumerator;
              rem_d     = '0;
              div_cnt_d = '0;
              state_d   = StDiv;
            end
          end
        end
      end
      StDiv: begin
        rem_d     = rem_ge ? TimeW'(rem_shift - {1'b0, period_q}) : rem_shift[TimeW-1:0];
        quo_d     = {quo_q[NumerW-2:0], rem_ge};
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == DivLast) begin
          state_d = StCmp;
        end
        note_cnt_d = '0;
        best_d     = '1;
        best_idx_d = '0;
      end
      StCmp: begin
        if (div_cnt_q != '0) begin
          // first compare cycle: saturate the quotient
          freq_d    = (quo_q > NumerW'(FreqMax)) ? FreqMax : quo_q[FreqW-1:0];
          div_cnt_d = '0;
        end else begin
          if (note_dist < best_q) begin
            best_d     = note_dist;
            best_idx_d = note_cnt_q;
          end
          note_cnt_d = note_cnt_q + NoteIdxW'(1);
          if (note_cnt_q == NoteLast) begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          match_d     = best_q > {tolerance_q, 8'h00};
          out_idx_d   = match_d ? '0 : best_idx_q;
          out_freq_d  = freq_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      last_edge_q <= '0;
      last_sig_q  <= '0;
      waiting_q   <= 1'b1;
      per_valid_q <= 1'b0;
      period_q    <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
      note_cnt_q  <= '0;
      debounce_q  <= DebounceRst;
      timeout_q   <= TimeoutRst;
      tolerance_q <= ToleranceRst;
      notes_lo_q  <= NotesLowRst;
      notes_hi_q  <= NotesHighRst;
    end else begin
      state_q     <= state_d;
      last_edge_q <= last_edge_d;
      last_sig_q  <= last_sig_d;
      waiting_q   <= waiting_d;
      per_valid_q <= per_valid_d;
      period_q    <= period_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
      note_cnt_q  <= note_cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegDebounce:  debounce_q  <= cfg_data_i[15:0];
          RegTimeout:   timeout_q   <= cfg_data_i[TimeW-1:0];
          RegTolerance: tolerance_q <= cfg_data_i[15:0];
          RegNotesLow:  notes_lo_q  <= cfg_data_i;
          RegNotesHigh: notes_hi_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    freq_q     <= freq_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    match_q    <= match_d;
    out_idx_q  <= out_idx_d;
    out_freq_q <= out_freq_d;
  end

  assign out_valid_o    = out_valid_q;
  assign match_status_o = match_q;
  assign note_index_o   = out_idx_q;
  assign frequency_q8_o = out_freq_q;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the edge period note classifier. Time-stamped edge
// and poll beats go in with random gaps while the result side stalls at
// random; an in-bench tuner model predicts every result and each one is
// compared field by field in arrival order. Directed checks cover the early
// first edge, debounce and timeout boundaries, timer wrap, frequency
// saturation, table ties and the tolerance edge; random tones with noise then
// run under a series of register settings that include both extremes.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import epnc_pkg::*;

  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned SettleCyc   = 45;
  localparam int unsigned PhaseItems  = 127;
  localparam int unsigned NumPhases   = 10;

  typedef struct packed {
    logic      unmatched;
    note_idx_t note;
    freq_t     freq;
  } note_result_t;

  logic      clk         = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      operation_i = 1'b0;
  time_t     time_us_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      cfg_valid_i = 1'b0;
  cfg_idx_t  cfg_index_i = '0;
  cfg_data_t cfg_data_i  = '0;

  logic      in_stall_o;
  logic      out_valid_o;
  logic      match_status_o;
  note_idx_t note_index_o;
  freq_t     frequency_q8_o;
  logic      cfg_ready_o;

  edge_period_note_classifier_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .time_us_i      (time_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .match_status_o (match_status_o),
    .note_index_o   (note_index_o),
    .frequency_q8_o (frequency_q8_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #10 clk = ~clk;

  // tuner model: registers and measurement state
  logic [15:0] dbc_us   = DebounceRst;
  time_t       tmo_us   = TimeoutRst;
  logic [15:0] tol_hz   = ToleranceRst;
  cfg_data_t   notes_lo = NotesLowRst;
  cfg_data_t   notes_hi = NotesHighRst;

  time_t edge_ts     = '0;
  time_t signal_ts   = '0;
  logic  arm_wait    = 1'b1;
  logic  period_held = 1'b0;
  time_t period_len  = '0;

  note_result_t notes_due[$];

  time_t       now_us;
  int unsigned edges_sent      = 0;
  int unsigned polls_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes      = 0;
  int unsigned settings_run    = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;
  int unsigned calm_in         = 0;
  int unsigned calm_out        = 0;
  int unsigned hold_left       = 0;

  function automatic logic [15:0] note_hz(int unsigned k);
    return (k < 4) ? notes_lo[16*k +: 16] : notes_hi[16*(k-4) +: 16];
  endfunction

  function automatic void classify_item(op_e op, time_t t);
    logic [31:0]  freq;
    logic [31:0]  best;
    logic [31:0]  note_dist;
    logic [31:0]  ref_q8;
    note_idx_t    best_k;
    note_result_t res;
    if (op == OpEdge) begin
      if (time_t'(t - edge_ts) > {16'd0, dbc_us}) begin
        signal_ts = t;
        if (arm_wait) begin
          arm_wait = 1'b0;
        end else begin
          period_len  = t - edge_ts;
          period_held = 1'b1;
        end
        edge_ts = t;
      end
      return;
    end
    if (t < signal_ts) begin
      signal_ts = t;
    end
    if (time_t'(t - signal_ts) > tmo_us) begin
      period_held = 1'b0;
      arm_wait    = 1'b1;
    end
    if (!period_held) begin
      return;
    end
    if (period_len == '0) begin
      freq = 32'(FreqMax);
    end else begin
      freq = 32'(FreqNumerator) / period_len;
      if (freq > 32'(FreqMax)) begin
        freq = 32'(FreqMax);
      end
    end
    best   = '1;
    best_k = '0;
    for (int unsigned k = 0; k < NUM_NOTES; k++) begin
      ref_q8    = {8'd0, note_hz(k), 8'd0};
      note_dist = (ref_q8 > freq) ? ref_q8 - freq : freq - ref_q8;
      if (note_dist < best) begin
        best   = note_dist;
        best_k = note_idx_t'(k);
      end
    end
    res.freq = freq[FreqW-1:0];
    if (best > {8'd0, tol_hz, 8'd0}) begin
      res.unmatched = 1'b1;
      res.note      = '0;
    end else begin
      res.unmatched = 1'b0;
      res.note      = best_k;
    end
    notes_due.push_back(res);
  endfunction

  function automatic int unsigned draw_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want_v);
    $display("mismatch: %s got %0d expected %0d (after %0d results)", what, got, want_v,
             results_checked);
    error_count++;
  endtask

  task automatic send_item(op_e op, time_t t);
    int unsigned gap;
    if (calm_in != 0) begin
      calm_in--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 2) calm_in = $urandom_range(20, 80);
      gap = draw_idle();
    end
    if (gap != 0) begin
      @(negedge clk) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    time_us_i   <= t;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    classify_item(op, t);
    if (op == OpEdge) edges_sent++;
    else polls_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk) in_valid_i <= 1'b0;
    while (notes_due.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk); while (cfg_ready_o !== 1'b1);
    case (idx)
      RegDebounce:  dbc_us   = data[15:0];
      RegTimeout:   tmo_us   = data[TimeW-1:0];
      RegTolerance: tol_hz   = data[15:0];
      RegNotesLow:  notes_lo = data;
      RegNotesHigh: notes_hi = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk) cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned pick_period();
    int unsigned r;
    int unsigned p;
    int unsigned f;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      f = note_hz($urandom_range(0, NUM_NOTES - 1));
      if (f == 0) f = 1;
      p = ((1000000 / f) * $urandom_range(95, 105)) / 100;
    end else if (r < 75) begin
      p = $urandom_range(62, 50000);
    end else if (r < 90) begin
      p = $urandom_range(1, 300);
    end else begin
      p = $urandom_range(50000, 2000000);
    end
    if (p <= dbc_us) p = dbc_us + 1 + $urandom_range(0, 100);
    if (p == 0) p = 1;
    return p;
  endfunction

  // a tone of steady edges with polls in between, plus bounces, silences,
  // backward timestamps and stray beats
  task automatic play_tone(int unsigned period, int unsigned count);
    int unsigned r;
    int unsigned jit;
    jit = period / 50;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        now_us += period - jit + $urandom_range(0, 2 * jit);
        send_item(OpEdge, now_us);
      end else if (r < 92) begin
        send_item(OpPoll, now_us + $urandom_range(0, period));
      end else if (r < 95) begin
        send_item(OpEdge, now_us + $urandom_range(0, dbc_us));
      end else if (r < 97) begin
        now_us += tmo_us + $urandom_range(1, 1000);
        send_item(OpPoll, now_us);
      end else if (r < 99) begin
        send_item(OpPoll, now_us - $urandom_range(1, 5000));
      end else begin
        send_item(op_e'($urandom_range(0, 1)), $urandom());
      end
    end
  endtask

  task automatic test_first_edge_and_timeout();
    send_item(OpPoll, 32'd0);
    send_item(OpEdge, 32'd50);
    send_item(OpEdge, 32'd100);
    send_item(OpEdge, 32'd101);
    send_item(OpEdge, 32'd2369);
    send_item(OpPoll, 32'd2400);
    send_item(OpEdge, 32'd3869);
    send_item(OpPoll, 32'd3900);
    send_item(OpPoll, 32'd103870);
    send_item(OpEdge, 32'd104000);
    send_item(OpEdge, 32'd107822);
    send_item(OpPoll, 32'd107900);
    now_us = 32'd107822;
  endtask

  task automatic test_saturation_and_wrap();
    quiesce();
    write_reg(RegDebounce, '0);
    write_reg(RegTimeout, '0);
    send_item(OpEdge, 32'hFFFF_FFFF);
    send_item(OpEdge, 32'h0000_0000);
    send_item(OpEdge, 32'h0000_0000);
    send_item(OpPoll, 32'h0000_0000);
    send_item(OpPoll, 32'h0000_0001);
    quiesce();
    write_reg(RegTimeout, cfg_data_t'({TimeW{1'b1}}));
    send_item(OpEdge, 32'h0000_0010);
    send_item(OpEdge, 32'hFFFF_FF00);
    send_item(OpPoll, 32'h0000_0020);
  endtask

  task automatic test_ties_and_tolerance();
    quiesce();
    write_reg(RegNotesLow, {16'd1000, 16'd1000, 16'd400, 16'd600});
    write_reg(RegNotesHigh, {4{16'd1000}});
    write_reg(RegTolerance, 64'd100);
    send_item(OpEdge, 32'h0000_1000);
    send_item(OpEdge, 32'h0000_1000 + 32'd2000);
    send_item(OpPoll, 32'h0000_1000 + 32'd2010);
    quiesce();
    write_reg(RegTolerance, 64'd99);
    send_item(OpPoll, 32'h0000_1000 + 32'd2020);
    quiesce();
    write_reg(RegTolerance, '0);
    write_reg(RegNotesHigh, {16'd500, 16'd1000, 16'd1000, 16'd1000});
    for (int k = int'(RegNotesHigh) + 1; k < (1 << CfgIdxW); k++) begin
      write_reg(cfg_idx_t'(k), {$urandom(), $urandom()});
    end
    send_item(OpPoll, 32'h0000_1000 + 32'd2030);
    now_us = 32'h0000_1000 + 32'd2000;
  endtask

  task automatic test_random_traffic();
    logic [15:0] dbc;
    logic [15:0] tol;
    time_t       tmo;
    cfg_data_t   lo;
    cfg_data_t   hi;
    int unsigned r;
    int unsigned start;
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      quiesce();
      case (phase)
        0: begin
          dbc = DebounceRst; tmo = TimeoutRst; tol = ToleranceRst;
          lo  = NotesLowRst; hi  = NotesHighRst;
        end
        1: begin
          dbc = '0; tmo = '0; tol = '0; lo = '0; hi = '0;
        end
        2: begin
          dbc = '1; tmo = '1; tol = '1; lo = '1; hi = '1;
        end
        default: begin
          r   = $urandom_range(0, 99);
          dbc = (r < 20) ? 16'd0 : (r < 30) ? 16'($urandom()) : 16'($urandom_range(0, 300));
          r   = $urandom_range(0, 99);
          tmo = (r < 10) ? '1 : (r < 20) ? time_t'($urandom())
                                         : time_t'($urandom_range(5000, 400000));
          r   = $urandom_range(0, 99);
          tol = (r < 10) ? 16'hFFFF : (r < 20) ? 16'd0 : 16'($urandom_range(0, 60));
          r   = $urandom_range(0, 99);
          if (r < 50) begin
            for (int k = 0; k < 4; k++) begin
              lo[16*k +: 16] = 16'($urandom_range(20, 4000));
              hi[16*k +: 16] = 16'($urandom_range(20, 4000));
            end
          end else if (r < 70) begin
            lo = {$urandom(), $urandom()};
            hi = {$urandom(), $urandom()};
          end else begin
            lo = NotesLowRst;
            hi = NotesHighRst;
          end
          now_us = $urandom();
        end
      endcase
      write_reg(RegDebounce, cfg_data_t'(dbc));
      write_reg(RegTimeout, cfg_data_t'(tmo));
      write_reg(RegTolerance, cfg_data_t'(tol));
      write_reg(RegNotesLow, lo);
      write_reg(RegNotesHigh, hi);
      settings_run++;
      start = edges_sent + polls_sent;
      while (edges_sent + polls_sent - start < PhaseItems) begin
        play_tone(pick_period(), $urandom_range(8, 40));
      end
    end
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm_out != 0) begin
      calm_out--;
      out_stall_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) < 2) calm_out = $urandom_range(20, 80);
      hold_left = draw_idle();
      out_stall_i <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  always @(posedge clk) begin : check_results
    note_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (notes_due.size() == 0) begin
        report_mismatch("unexpected result beat, frequency", frequency_q8_o, 0);
      end else begin
        want = notes_due.pop_front();
        if (match_status_o !== want.unmatched)
          report_mismatch("match_status", match_status_o, want.unmatched);
        if (note_index_o !== want.note)
          report_mismatch("note_index", note_index_o, want.note);
        if (frequency_q8_o !== want.freq)
          report_mismatch("frequency_q8", frequency_q8_o, want.freq);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               notes_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst_ni <= 1'b1;
    test_first_edge_and_timeout();
    test_saturation_and_wrap();
    test_ties_and_tolerance();
    test_random_traffic();
    quiesce();
    repeat (SettleCyc) @(posedge clk);
    $display("summary: %0d edge and %0d poll beats sent, %0d note results checked",
             edges_sent, polls_sent, results_checked);
    $display("summary: %0d register writes, %0d random settings, %0d mismatches",
             reg_writes, settings_run, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
